>>> hw/rtl/wfsa_pkg.sv
// Package for the worst-fit segment allocator.
// Holds the opcode, state and segment types shared by all modules.
// No dependencies.
package wfsa_pkg;

	localparam int AddrW = 31;

	typedef enum logic {
		OP_ALLOC   = 1'b0,
		OP_RELEASE = 1'b1
	} opcode_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_TAGRD,
		ST_TAGWAIT,
		ST_SCAN,
		ST_SCANLAST,
		ST_ALLOCWR,
		ST_RELSCAN,
		ST_RELLAST,
		ST_RELWR,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [AddrW-1:0] hi;
		logic [AddrW-1:0] lo;
	} seg_t;

endpackage

>>> hw/rtl/worst_fit_segment_allocator_top.sv
// Top level of the worst-fit segment allocator with coalescing.
// Uses wfsa_pkg; holds the free-segment and block memories and the sequencer.
//
// Channel  | dir | tdata fields (low bit up)           | tuser
// s_axis   | in  | alloc_size[30:0], tag[41:31], pad   | opcode
// m_axis   | out | start_address[30:0], pad            | failed
// cfg      | in  | mem_size[30:0] on cfg_wdata         | -
//
// A scanning allocate reads and waits for its tag entry, scans the free table at
// one entry per cycle over MAX_TAGS+1 entries, makes the last compare, writes back
// and loads the output register, which raises the result. A release scans the same way,
// writes the merged segment back and raises no result; an allocate with a bad or used
// tag or a zero size skips the scan and goes straight to the output load.
// Reset, and every mem_size write, starts a clearing pass over the free and block
// tables during which s_axis_tready stays low.
// A result waits in the output register; the next item is taken once it
// has been transferred.
module worst_fit_segment_allocator_top #(
	parameter int MAX_TAGS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [30:0] cfg_wdata,      // mem_size
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // alloc_size[30:0], tag[41:31]
	input  logic        s_axis_tuser,   // opcode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // start_address[30:0]
	output logic        m_axis_tuser    // failed
);
	import wfsa_pkg::*;

	localparam int NSEG = MAX_TAGS + 1;
	localparam int SW = $clog2(NSEG);
	localparam int TW = $clog2(MAX_TAGS);

	// Free table: segment bounds and valid flag in one memory word.
	logic [2*AddrW:0] fmem [NSEG];
	// Block table: block bounds and valid flag in one memory word.
	logic [2*AddrW:0] bmem [MAX_TAGS];

	state_t state_q, state_d;
	logic [AddrW-1:0] msize_q;
	logic [SW-1:0]    idx_q;
	logic             op_q;
	logic [AddrW-1:0] size_q;
	logic [TW-1:0]    tidx_q;
	logic             tagok_q;

	// scan results
	logic             found_q;
	logic [SW-1:0]    best_q;
	logic [AddrW-1:0] blo_q, bhi_q;
	logic [AddrW:0]   blen_q;
	logic [AddrW-1:0] rlo_q, rhi_q;
	logic             hole_q;
	logic [SW-1:0]    hidx_q;

	logic [2*AddrW:0] frd_s1;
	logic [SW-1:0]    frd_idx_s1;
	logic [2*AddrW:0] brd_s1;

	logic [AddrW-1:0] res_addr_q;
	logic             res_fail_q;
	logic             mvalid_q;

	// memory port controls
	logic             fwe;
	logic [SW-1:0]    fwa;
	logic [2*AddrW:0] fwd;

	logic [10:0]      in_tag;
	logic [AddrW-1:0] in_size;
	assign in_size = s_axis_tdata[30:0];
	assign in_tag  = s_axis_tdata[41:31];

	assign s_axis_tready = (state_q == ST_IDLE) && !mvalid_q;
	assign m_axis_tvalid = mvalid_q;
	assign m_axis_tdata  = {1'b0, res_addr_q};
	assign m_axis_tuser  = res_fail_q;

	// current read entry
	seg_t             cur;
	logic             cur_v;
	logic [AddrW:0]   cur_len;
	assign cur     = seg_t'(frd_s1[2*AddrW-1:0]);
	assign cur_v   = frd_s1[2*AddrW];
	assign cur_len = {1'b0, cur.hi} - {1'b0, cur.lo} + 1'b1;

	// block entry of the accepted tag
	seg_t             brd_seg;
	logic             brd_v;
	assign brd_seg = seg_t'(brd_s1[2*AddrW-1:0]);
	assign brd_v   = brd_s1[2*AddrW];

	always_ff @(posedge clk) begin
		if (fwe)
			fmem[fwa] <= fwd;
		frd_s1     <= fmem[idx_q];
		frd_idx_s1 <= idx_q;
		brd_s1     <= bmem[tidx_q];
		if (state_q == ST_INIT && idx_q < SW'(MAX_TAGS))
			bmem[idx_q[TW-1:0]] <= '0;
		else if (state_q == ST_ALLOCWR && found_q && blen_q >= {1'b0, size_q})
			bmem[tidx_q] <= {1'b1, blo_q + size_q - 1'b1, blo_q};
		else if (state_q == ST_TAGWAIT && op_q == OP_RELEASE && tagok_q && brd_v)
			bmem[tidx_q] <= '0;
	end

	always_comb begin
		state_d = state_q;
		fwe = 1'b0;
		fwa = idx_q;
		fwd = '0;
		case (state_q)
			ST_INIT: begin
				fwe = 1'b1;
				fwd = ((idx_q == '0) && (msize_q != '0)) ?
					{1'b1, msize_q, {{(AddrW-1){1'b0}}, 1'b1}} : '0;
				if (idx_q == SW'(NSEG-1))
					state_d = ST_IDLE;
			end
			ST_IDLE:
				if (s_axis_tvalid && s_axis_tready)
					state_d = ST_TAGRD;
			ST_TAGRD:
				state_d = ST_TAGWAIT;
			ST_TAGWAIT: begin
				if (op_q == OP_RELEASE)
					state_d = (tagok_q && brd_v) ? ST_RELSCAN : ST_IDLE;
				else if (!tagok_q || brd_v || size_q == '0)
					state_d = ST_OUT;
				else
					state_d = ST_SCAN;
			end
			ST_SCAN:
				if (idx_q == SW'(NSEG-1))
					state_d = ST_SCANLAST;
			ST_SCANLAST:
				state_d = ST_ALLOCWR;
			ST_ALLOCWR: begin
				state_d = ST_OUT;
				if (found_q && blen_q >= {1'b0, size_q}) begin
					fwe = 1'b1;
					fwa = best_q;
					fwd = (blen_q == {1'b0, size_q}) ? '0 :
						{1'b1, bhi_q, blo_q + size_q};
				end
			end
			ST_RELSCAN: begin
				if (idx_q == SW'(NSEG-1))
					state_d = ST_RELLAST;
			end
			ST_RELLAST:
				state_d = ST_RELWR;
			ST_RELWR: begin
				fwe = 1'b1;
				fwa = hidx_q;
				fwd = {1'b1, rhi_q, rlo_q};
				state_d = ST_IDLE;
			end
			ST_OUT:
				state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
		// merge scan: invalidate absorbed neighbours in the cycle after their read
		if ((state_q == ST_RELSCAN || state_q == ST_RELLAST) && idx_q != '0 && cur_v &&
			({1'b0, cur.hi} + 1'b1 == {1'b0, rlo_q} ||
			 {1'b0, rhi_q} + 1'b1 == {1'b0, cur.lo})) begin
			fwe = 1'b1;
			fwa = frd_idx_s1;
			fwd = '0;
		end
		if (cfg_we)
			state_d = ST_INIT;
	end

	// Release scan reads entry idx_q; previous entry is frd_s1 (frd_idx_s1).
	// idx_q != 0 marks that a real entry is in frd_s1 during RELSCAN.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_INIT;
			msize_q  <= 31'd1024;
			idx_q    <= '0;
			mvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mvalid_q && m_axis_tready)
				mvalid_q <= 1'b0;
			if (cfg_we) begin
				msize_q  <= cfg_wdata;
				idx_q    <= '0;
			end else begin
				case (state_q)
					ST_INIT:
						idx_q <= (idx_q == SW'(NSEG-1)) ? '0 : idx_q + 1'b1;
					ST_TAGWAIT:
						idx_q <= '0;
					ST_SCAN, ST_RELSCAN:
						if (idx_q != SW'(NSEG-1))
							idx_q <= idx_q + 1'b1;
					ST_RELLAST, ST_SCANLAST:
						idx_q <= '0;
					ST_OUT:
						mvalid_q <= 1'b1;
					ST_TAGRD: ;
					default: ;
				endcase
			end
		end
	end

	// payload / scan registers
	logic scan_rd;
	assign scan_rd = ((state_q == ST_SCAN || state_q == ST_RELSCAN) &&
		frd_idx_s1 != idx_q) || state_q == ST_SCANLAST || state_q == ST_RELLAST;

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_axis_tvalid && s_axis_tready) begin
			op_q    <= s_axis_tuser;
			size_q  <= in_size;
			tagok_q <= (in_tag >= 11'd1) && ({21'd0, in_tag} <= 32'(MAX_TAGS));
			tidx_q  <= TW'(in_tag - 11'd1);
		end
		if (state_q == ST_TAGWAIT) begin
			found_q <= 1'b0;
			hole_q  <= 1'b0;
			rlo_q   <= brd_seg.lo;
			rhi_q   <= brd_seg.hi;
		end
		if (scan_rd && state_q != ST_RELSCAN && state_q != ST_RELLAST && cur_v &&
			(!found_q || cur_len > blen_q || (cur_len == blen_q && cur.lo < blo_q))) begin
			found_q <= 1'b1;
			best_q  <= frd_idx_s1;
			blen_q  <= cur_len;
			blo_q   <= cur.lo;
			bhi_q   <= cur.hi;
		end
		if (state_q == ST_ALLOCWR || state_q == ST_OUT) begin
			if (state_q == ST_ALLOCWR) begin
				res_fail_q <= !(found_q && blen_q >= {1'b0, size_q});
				res_addr_q <= (found_q && blen_q >= {1'b0, size_q}) ? blo_q : '0;
			end
		end
		if (state_q == ST_TAGWAIT) begin
			res_fail_q <= 1'b1;
			res_addr_q <= '0;
		end
		if ((state_q == ST_RELSCAN || state_q == ST_RELLAST) && idx_q != '0) begin
			if (cur_v && {1'b0, cur.hi} + 1'b1 == {1'b0, rlo_q})
				rlo_q <= cur.lo;
			else if (cur_v && {1'b0, rhi_q} + 1'b1 == {1'b0, cur.lo})
				rhi_q <= cur.hi;
			if (!hole_q && (!cur_v || {1'b0, cur.hi} + 1'b1 == {1'b0, rlo_q} ||
				{1'b0, rhi_q} + 1'b1 == {1'b0, cur.lo})) begin
				hole_q <= 1'b1;
				hidx_q <= frd_idx_s1;
			end
		end
	end

	// a new item is only accepted while the output register is free
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !m_axis_tvalid)
		else $error("accepted while result pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
		else $error("result dropped");
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> m_axis_tdata[30:0] != '0)
		else $error("granted block at address zero");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RELWR) |-> hole_q)
		else $error("no free entry for merged segment");

endmodule
